>>> rtl/core/packed_5bit_fifo_top_macros.svh
// Assertion macros for the packed 5-bit FIFO.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef PACKED_5BIT_FIFO_TOP_MACROS_SVH
`define PACKED_5BIT_FIFO_TOP_MACROS_SVH

// property holds on every clock edge outside reset
`define PF5_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// antecedent implies consequent on the next clock edge
`define PF5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/core/pf5_pkg.sv
// Shared constants, types and codes for the packed 5-bit FIFO.
// No dependencies.
package pf5_pkg;

  localparam int DEPTH       = 64;
  localparam int ELEM_BITS   = 5;
  localparam int STORE_BYTES = (DEPTH * ELEM_BITS + 7) / 8;
  localparam int BYTE_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(DEPTH * ELEM_BITS);
  localparam int LIM_W       = $clog2(DEPTH * ELEM_BITS + 1);
  localparam int CAP_W       = $clog2(DEPTH + 1);
  localparam int WIN_W       = 16;
  localparam int CAP_RESET   = 64;

  localparam logic [ELEM_BITS-1:0] ELEM_MASK = '1;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // request to the packed store: read a two-byte window, or write it back
  typedef struct packed {
    logic              rd_en;
    logic [BYTE_W-1:0] rd_byte;
    logic              wr_en;
    logic [WIN_W-1:0]  wr_win;
  } store_req_t;

endpackage

>>> rtl/core/pf5_store.sv
// Packed byte store split into even and odd byte banks, two-byte window access.
// Depends on pf5_pkg. Write targets the window of the last read.
module pf5_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pf5_pkg::store_req_t      req_i,
  output logic [pf5_pkg::WIN_W-1:0] rd_win_o
);
  import pf5_pkg::*;

  localparam int EV_DEPTH = (STORE_BYTES + 1) / 2;
  localparam int OD_DEPTH = STORE_BYTES / 2;
  localparam int EV_AW    = $clog2(EV_DEPTH);
  localparam int OD_AW    = $clog2(OD_DEPTH);

  logic [7:0] ev_mem [EV_DEPTH];
  logic [7:0] od_mem [OD_DEPTH];

  logic [BYTE_W:0]   byte_p1;
  logic [EV_AW-1:0]  ev_addr;
  logic [OD_AW-1:0]  od_addr;
  logic              hi_ok;
  logic              ev_en, od_en;

  logic [EV_AW-1:0]  ev_addr_q;
  logic [OD_AW-1:0]  od_addr_q;
  logic              lo_even_q, ev_en_q, od_en_q;
  logic [7:0]        ev_rd_q, od_rd_q;
  logic [7:0]        lo_wr, hi_wr;

  assign byte_p1 = {1'b0, req_i.rd_byte} + 1'b1;
  assign ev_addr = EV_AW'(byte_p1 >> 1);
  assign od_addr = OD_AW'(req_i.rd_byte >> 1);
  assign hi_ok   = (byte_p1 < (BYTE_W+1)'(STORE_BYTES));
  assign ev_en   = !req_i.rd_byte[0] || hi_ok;
  assign od_en   = req_i.rd_byte[0] || hi_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_even_q <= 1'b1;
      ev_en_q   <= 1'b0;
      od_en_q   <= 1'b0;
    end else if (req_i.rd_en) begin
      lo_even_q <= !req_i.rd_byte[0];
      ev_en_q   <= ev_en;
      od_en_q   <= od_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      ev_addr_q <= ev_addr;
      od_addr_q <= od_addr;
      if (ev_en) begin
        ev_rd_q <= ev_mem[ev_addr];
      end
      if (od_en) begin
        od_rd_q <= od_mem[od_addr];
      end
    end
  end

  assign lo_wr = req_i.wr_win[7:0];
  assign hi_wr = req_i.wr_win[WIN_W-1:8];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      if (ev_en_q) begin
        ev_mem[ev_addr_q] <= lo_even_q ? lo_wr : hi_wr;
      end
      if (od_en_q) begin
        od_mem[od_addr_q] <= lo_even_q ? hi_wr : lo_wr;
      end
    end
  end

  assign rd_win_o = lo_even_q ? {od_rd_q, ev_rd_q} : {ev_rd_q, od_rd_q};

endmodule

>>> rtl/core/packed_5bit_fifo_top.sv
// Top level of the packed 5-bit FIFO: request handling, pointers, result register.
// Depends on pf5_pkg, pf5_store and packed_5bit_fifo_top_macros.svh.
//
//  channel   dir  payload                                    transaction
//  s_axis    in   tuser: req_type, tdata: element_in         tvalid & tready
//  m_axis    out  tuser: status, tdata: element_out, fill    tvalid & tready
//  cfg       in   data: capacity                             cfg_valid & cfg_ready
//
// One request at a time: the accept cycle issues the store read; the next cycle
// uses the two-byte window, writes it back on an enqueue and loads the result.
// Reset empties the queue and sets capacity 64; store content needs no clearing.
// A request is taken only when the result register is free or drained this cycle,
// and not while a configuration write is offered.
`include "packed_5bit_fifo_top_macros.svh"

module packed_5bit_fifo_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] element_in
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] element_out, [11:5] fill_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pf5_pkg::CAP_W-1:0] cfg_data_i
);
  import pf5_pkg::*;

  typedef enum logic {S_IDLE, S_PROC} state_e;

  state_e               state_q;
  logic [CAP_W-1:0]     cap_q, held_q;
  logic [LIM_W-1:0]     lim_q;
  logic [POS_W-1:0]     head_q, tail_q;
  logic                 req_q;
  logic [ELEM_BITS-1:0] elem_q;
  logic [2:0]           off_q;

  logic                 m_valid_q;
  status_e              m_status_q;
  logic [ELEM_BITS-1:0] m_elem_q;
  logic [CAP_W-1:0]     m_fill_q;

  logic                 s_acc, cfg_acc;
  logic [POS_W-1:0]     pos;
  logic [CAP_W-1:0]     cap_new;
  store_req_t           st_req;
  logic [WIN_W-1:0]     rd_win, shifted, new_win;
  logic                 do_enq, do_deq;
  logic [POS_W-1:0]     head_nx, tail_nx;

  function automatic logic [POS_W-1:0] advance(logic [POS_W-1:0] p, logic [LIM_W-1:0] lim);
    logic [LIM_W:0] nx;
    nx = (LIM_W+1)'(p) + (LIM_W+1)'(ELEM_BITS);
    return (nx >= {1'b0, lim}) ? '0 : POS_W'(nx);
  endfunction

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i && (!m_valid_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    priority if (cfg_data_i == '0) begin
      cap_new = CAP_W'(1);
    end else if (cfg_data_i > CAP_W'(DEPTH)) begin
      cap_new = CAP_W'(DEPTH);
    end else begin
      cap_new = cfg_data_i;
    end
  end

  assign pos = (s_axis_tuser[0] == REQ_DEQ) ? tail_q : head_q;

  assign shifted = rd_win >> off_q;
  assign new_win = (rd_win & ~(WIN_W'(ELEM_MASK) << off_q)) | (WIN_W'(elem_q) << off_q);
  assign do_enq  = (state_q == S_PROC) && (req_q == REQ_ENQ) && (held_q < cap_q);
  assign do_deq  = (state_q == S_PROC) && (req_q == REQ_DEQ) && (held_q != '0);
  assign head_nx = advance(head_q, lim_q);
  assign tail_nx = advance(tail_q, lim_q);

  always_comb begin
    st_req.rd_en   = s_acc;
    st_req.rd_byte = BYTE_W'(pos >> 3);
    st_req.wr_en   = do_enq;
    st_req.wr_win  = new_win;
  end

  pf5_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (st_req),
    .rd_win_o (rd_win)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= CAP_W'(CAP_RESET);
      lim_q      <= LIM_W'(CAP_RESET * ELEM_BITS);
      held_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      m_valid_q  <= 1'b0;
      m_status_q <= ST_DONE;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_acc) begin
            cap_q  <= cap_new;
            lim_q  <= LIM_W'(cap_new * ELEM_BITS);
            held_q <= '0;
            head_q <= '0;
            tail_q <= '0;
          end else if (s_acc) begin
            state_q <= S_PROC;
          end
        end
        S_PROC: begin
          state_q   <= S_IDLE;
          m_valid_q <= 1'b1;
          if (req_q == REQ_ENQ) begin
            if (do_enq) begin
              m_status_q <= ST_DONE;
              head_q     <= head_nx;
              held_q     <= held_q + 1'b1;
            end else begin
              m_status_q <= ST_FULL;
            end
          end else begin
            if (do_deq) begin
              m_status_q <= ST_DONE;
              tail_q     <= tail_nx;
              held_q     <= held_q - 1'b1;
            end else begin
              m_status_q <= ST_EMPTY;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q  <= s_axis_tuser[0];
      elem_q <= s_axis_tdata[ELEM_BITS-1:0];
      off_q  <= pos[2:0];
    end
    if (state_q == S_PROC) begin
      m_elem_q <= do_deq ? shifted[ELEM_BITS-1:0] : '0;
      priority if (do_enq) begin
        m_fill_q <= held_q + 1'b1;
      end else if (do_deq) begin
        m_fill_q <= held_q - 1'b1;
      end else begin
        m_fill_q <= held_q;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {4'b0, m_fill_q, m_elem_q};

  `PF5_ASSERT(a_held_le_cap, held_q <= cap_q)
  `PF5_ASSERT_NEXT(a_accept_to_proc, s_acc, state_q == S_PROC)
  `PF5_ASSERT(a_proc_slot_free, (state_q == S_PROC) |-> !m_valid_q)

endmodule
